// ===== hdl/refcounted_buffer_tracker_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the buffer tracker
// Shared property forms, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_BUFFER_TRACKER_CORE_DEFINES_SVH
`define REFCOUNTED_BUFFER_TRACKER_CORE_DEFINES_SVH

// same-cycle implication
`define RBT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RBT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/rbt_pkg.sv =====
// ----------------------------------------------------------------------------
// rbt_pkg
// Types, codes and defaults shared by the buffer tracker modules.
// ----------------------------------------------------------------------------
package rbt_pkg;

   localparam int TABLE_ENTRIES_DEF = 64;
   localparam int REF_BITS_DEF      = 16;

   // front queue
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = 1;
   localparam int QCNT_W      = 2;

   // request kind codes
   localparam logic [2:0] KIND_ALLOC   = 3'd0;
   localparam logic [2:0] KIND_MARK    = 3'd1;
   localparam logic [2:0] KIND_QUERY   = 3'd2;
   localparam logic [2:0] KIND_RELEASE = 3'd3;
   localparam logic [2:0] KIND_DEALLOC = 3'd4;
   localparam logic [2:0] KIND_CLEAR   = 3'd5;

   typedef enum logic [2:0] {
      ST_DONE      = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_OVER_CAP  = 3'd2,
      ST_FULL      = 3'd3,
      ST_PRESENT   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      OP_ALLOC,
      OP_MARK,
      OP_QUERY,
      OP_RELEASE,
      OP_DEALLOC,
      OP_CLEAR,
      OP_NONE
   } op_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_LOOKUP,
      BK_ENCODE,
      BK_READ,
      BK_EXEC
   } state_type;

   typedef struct packed {
      op_type      op;
      logic [31:0] transfer_id;
      logic [31:0] request_bytes;
      logic [15:0] initial_refs;
   } cmd_type;

   function automatic op_type decode_kind(input logic [2:0] kind);
      op_type op;
      case (kind)
         KIND_ALLOC:   op = OP_ALLOC;
         KIND_MARK:    op = OP_MARK;
         KIND_QUERY:   op = OP_QUERY;
         KIND_RELEASE: op = OP_RELEASE;
         KIND_DEALLOC: op = OP_DEALLOC;
         KIND_CLEAR:   op = OP_CLEAR;
         default:      op = OP_NONE;
      endcase
      return op;
   endfunction

endpackage

// ===== hdl/rbt_ifs.sv =====
// ----------------------------------------------------------------------------
// rbt_req_if / rbt_rsp_if
// Valid/ready channels for request and response words.
// ----------------------------------------------------------------------------
interface rbt_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [31:0] transfer_id;
   logic [31:0] request_bytes;
   logic [15:0] initial_refs;

   modport source (output valid, kind, transfer_id, request_bytes, initial_refs,
                   input ready);
   modport sink   (input valid, kind, transfer_id, request_bytes, initial_refs,
                   output ready);
endinterface

interface rbt_rsp_if;
   logic        valid;
   logic        ready;
   logic        ok;
   logic [2:0]  status;
   logic        present;
   logic        entry_ready;
   logic        freed;
   logic [31:0] bytes_in_use;

   modport source (output valid, ok, status, present, entry_ready, freed, bytes_in_use,
                   input ready);
   modport sink   (input valid, ok, status, present, entry_ready, freed, bytes_in_use,
                   output ready);
endinterface

// ===== hdl/rbt_ram.sv =====
// ----------------------------------------------------------------------------
// rbt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rbt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/rbt_front.sv =====
// ----------------------------------------------------------------------------
// rbt_front
// Accepts request words, decodes the kind and queues them for the back end.
// ----------------------------------------------------------------------------
module rbt_front (
   input  logic             clock,
   input  logic             reset,
   rbt_req_if.sink          req_ch,
   output rbt_pkg::cmd_type cmd,
   output logic             cmd_valid,
   input  logic             cmd_ready
);
   import rbt_pkg::*;

   cmd_type             q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push, pop;
   cmd_type             new_cmd;

   assign req_ch.ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push         = req_ch.valid && req_ch.ready;
   assign cmd_valid    = (count_ff != '0);
   assign pop          = cmd_valid && cmd_ready;
   assign cmd          = q_ff[rd_ptr_ff];

   always_comb begin
      new_cmd.op            = decode_kind(req_ch.kind);
      new_cmd.transfer_id   = req_ch.transfer_id;
      new_cmd.request_bytes = req_ch.request_bytes;
      new_cmd.initial_refs  = req_ch.initial_refs;
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// ===== hdl/rbt_back.sv =====
// ----------------------------------------------------------------------------
// rbt_back
// Holds the entry table and byte total, runs one queued word at a time and
// registers its response word.
// ----------------------------------------------------------------------------
module rbt_back #(
   parameter int TABLE_ENTRIES = rbt_pkg::TABLE_ENTRIES_DEF,
   parameter int REF_BITS      = rbt_pkg::REF_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  rbt_pkg::cmd_type cmd,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  logic [31:0]      capacity,
   rbt_rsp_if.source        rsp_ch
);
   import rbt_pkg::*;

   localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int WORD_W = 32 + REF_BITS + 1;

   state_type                state_ff, state_in;
   cmd_type                  cmd_ff;
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [31:0]              slot_id_ff [TABLE_ENTRIES];
   logic [31:0]              used_ff, used_in;

   logic [TABLE_ENTRIES-1:0] match_ff, match_in;
   logic [TABLE_ENTRIES-1:0] free_ff;
   logic [TABLE_ENTRIES-1:0] free_low;
   logic                     hit_ff, full_ff, over_ff;
   logic [IDX_W-1:0]         hit_idx_ff, free_idx_ff;
   logic [IDX_W-1:0]         hit_idx_enc, free_idx_enc;
   logic [32:0]              cap_sum;

   logic                     take_cmd, exec_go;
   logic                     id_we, ram_we;
   logic [IDX_W-1:0]         ram_waddr;
   logic [WORD_W-1:0]        ram_wdata, ram_rdata;
   logic [31:0]              rd_bytes;
   logic [REF_BITS-1:0]      rd_refs, new_refs, alloc_refs;
   logic                     rd_ready;
   logic [31:0]              refs_wide;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     ok_in, present_in, entry_ready_in, freed_in;
   status_type               status_in;
   logic                     ok_ff, present_ff, entry_ready_ff, freed_ff;
   status_type               status_ff;

   // ---- state machine ----
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE:   if (cmd_valid) state_in = BK_LOOKUP;
         BK_LOOKUP: state_in = BK_ENCODE;
         BK_ENCODE: state_in = BK_READ;
         BK_READ:   state_in = BK_EXEC;
         BK_EXEC:   if (!rsp_valid_ff || rsp_ch.ready) state_in = BK_IDLE;
         default:   state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      take_cmd = 1'b0;
      exec_go  = 1'b0;
      case (state_ff)
         BK_IDLE: take_cmd = 1'b1;
         BK_EXEC: exec_go  = !rsp_valid_ff || rsp_ch.ready;
         default: begin
            take_cmd = 1'b0;
            exec_go  = 1'b0;
         end
      endcase
   end

   assign cmd_ready = take_cmd;

   // ---- lookup: parallel id compare ----
   always_comb begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         match_in[i] = valid_ff[i] && (slot_id_ff[i] == cmd_ff.transfer_id);
      end
   end

   // ---- encode: match is one-hot, free slot is the lowest clear valid bit ----
   assign free_low = free_ff & (~free_ff + TABLE_ENTRIES'(1));

   always_comb begin
      hit_idx_enc  = '0;
      free_idx_enc = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
         if (match_ff[i]) hit_idx_enc  = hit_idx_enc  | IDX_W'(i);
         if (free_low[i]) free_idx_enc = free_idx_enc | IDX_W'(i);
      end
   end

   assign cap_sum = {1'b0, used_ff} + {1'b0, cmd_ff.request_bytes};

   // ---- entry payload: bytes, refs, ready ----
   rbt_ram #(
      .WIDTH (WORD_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_we && exec_go),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (hit_idx_ff),
      .rd_data (ram_rdata)
   );

   assign rd_bytes   = ram_rdata[WORD_W-1 -: 32];
   assign rd_refs    = ram_rdata[REF_BITS:1];
   assign rd_ready   = ram_rdata[0];
   assign refs_wide  = 32'(cmd_ff.initial_refs);
   assign alloc_refs = refs_wide[REF_BITS-1:0];
   assign new_refs   = (rd_refs == '0) ? '0 : rd_refs - REF_BITS'(1);

   // ---- execute ----
   always_comb begin
      valid_in       = valid_ff;
      used_in        = used_ff;
      id_we          = 1'b0;
      ram_we         = 1'b0;
      ram_waddr      = hit_idx_ff;
      ram_wdata      = {rd_bytes, rd_refs, rd_ready};
      ok_in          = 1'b0;
      status_in      = ST_DONE;
      present_in     = hit_ff;
      entry_ready_in = hit_ff && rd_ready;
      freed_in       = 1'b0;
      case (cmd_ff.op)
         OP_ALLOC: begin
            if (hit_ff) begin
               ok_in     = 1'b1;
               status_in = ST_PRESENT;
            end else if (over_ff) begin
               status_in = ST_OVER_CAP;
            end else if (full_ff) begin
               status_in = ST_FULL;
            end else begin
               ok_in                 = 1'b1;
               present_in            = 1'b1;
               entry_ready_in        = 1'b0;
               valid_in[free_idx_ff] = 1'b1;
               used_in               = used_ff + cmd_ff.request_bytes;
               id_we                 = 1'b1;
               ram_we                = 1'b1;
               ram_waddr             = free_idx_ff;
               ram_wdata             = {cmd_ff.request_bytes, alloc_refs, 1'b0};
            end
         end
         OP_MARK: begin
            if (hit_ff) begin
               ok_in          = 1'b1;
               entry_ready_in = 1'b1;
               ram_we         = 1'b1;
               ram_wdata      = {rd_bytes, rd_refs, 1'b1};
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         OP_QUERY: begin
            if (hit_ff) begin
               ok_in = rd_ready;
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         OP_RELEASE: begin
            if (!hit_ff) begin
               status_in = ST_NOT_FOUND;
            end else if (new_refs == '0) begin
               ok_in                = 1'b1;
               freed_in             = 1'b1;
               present_in           = 1'b0;
               entry_ready_in       = 1'b0;
               valid_in[hit_idx_ff] = 1'b0;
               used_in              = used_ff - rd_bytes;
            end else begin
               ram_we    = 1'b1;
               ram_wdata = {rd_bytes, new_refs, rd_ready};
            end
         end
         OP_DEALLOC: begin
            if (hit_ff) begin
               ok_in                = 1'b1;
               freed_in             = 1'b1;
               present_in           = 1'b0;
               entry_ready_in       = 1'b0;
               valid_in[hit_idx_ff] = 1'b0;
               used_in              = used_ff - rd_bytes;
            end else begin
               status_in = ST_NOT_FOUND;
            end
         end
         OP_CLEAR: begin
            ok_in          = 1'b1;
            present_in     = 1'b0;
            entry_ready_in = 1'b0;
            valid_in       = '0;
            used_in        = '0;
         end
         default: begin
            ok_in = 1'b0;
         end
      endcase
   end

   assign rsp_valid_in = exec_go ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   // ---- control registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         valid_ff     <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (exec_go) begin
            valid_ff <= valid_in;
            used_ff  <= used_in;
         end
      end
   end

   // ---- payload registers ----
   always_ff @(posedge clock) begin
      if (take_cmd && cmd_valid) begin
         cmd_ff <= cmd;
      end
      match_ff <= match_in;
      free_ff  <= ~valid_ff;
      if (state_ff == BK_ENCODE) begin
         hit_ff      <= |match_ff;
         hit_idx_ff  <= hit_idx_enc;
         full_ff     <= ~|free_ff;
         free_idx_ff <= free_idx_enc;
         over_ff     <= cap_sum > {1'b0, capacity};
      end
      if (exec_go && id_we) begin
         slot_id_ff[free_idx_ff] <= cmd_ff.transfer_id;
      end
      if (exec_go) begin
         ok_ff          <= ok_in;
         status_ff      <= status_in;
         present_ff     <= present_in;
         entry_ready_ff <= entry_ready_in;
         freed_ff       <= freed_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.ok           = ok_ff;
   assign rsp_ch.status       = status_ff;
   assign rsp_ch.present      = present_ff;
   assign rsp_ch.entry_ready  = entry_ready_ff;
   assign rsp_ch.freed        = freed_ff;
   assign rsp_ch.bytes_in_use = used_ff;

endmodule

// ===== hdl/refcounted_buffer_tracker_core.sv =====
// ----------------------------------------------------------------------------
// refcounted_buffer_tracker_core
// Reference-counted buffer space tracker keyed by transfer id.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries request words (kind, transfer_id, request_bytes,
//   initial_refs); rsp_ch returns one response word per request, in order.
//   csr_wr_en/csr_wr_data write the capacity register; write it only while
//   no request is outstanding.
//   The back end runs one request at a time through id compare, index
//   encode, slot RAM read and table update, and takes no new request
//   until the response word of the last one is registered.
//   A two-word front queue keeps taking requests while the back end works
//   or while a response waits.
//   When the receiver stalls, the response word holds and the back end
//   waits before updating the table; the queue then fills and req_ch.ready
//   drops.
//   Reset clears all entry valid bits, the byte total and the capacity;
//   no sweep follows.
// ----------------------------------------------------------------------------
module refcounted_buffer_tracker_core #(
   parameter int TABLE_ENTRIES = rbt_pkg::TABLE_ENTRIES_DEF,
   parameter int REF_BITS      = rbt_pkg::REF_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   rbt_req_if.sink     req_ch,
   rbt_rsp_if.source   rsp_ch,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);
   import rbt_pkg::*;

   cmd_type     cmd;
   logic        cmd_valid;
   logic        cmd_ready;
   logic [31:0] capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= '0;
      end else if (csr_wr_en) begin
         capacity_ff <= csr_wr_data;
      end
   end

   rbt_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready)
   );

   rbt_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .REF_BITS      (REF_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .capacity  (capacity_ff),
      .rsp_ch    (rsp_ch)
   );

endmodule

// ===== hdl/rbt_checker.sv =====
// ----------------------------------------------------------------------------
// rbt_checker
// Port-level checks on the tracker's response words.
// ----------------------------------------------------------------------------
`include "refcounted_buffer_tracker_core_defines.svh"

module rbt_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_ok,
   input logic [2:0]  rsp_status,
   input logic        rsp_present,
   input logic        rsp_entry_ready,
   input logic        rsp_freed,
   input logic [31:0] rsp_bytes_in_use
);
   import rbt_pkg::*;

   `RBT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_ok, rsp_status, rsp_present, rsp_entry_ready, rsp_freed, rsp_bytes_in_use}), "response word changed while stalled")
   `RBT_ASSERT_NOW(a_not_found, rsp_valid && (rsp_status == ST_NOT_FOUND), !rsp_ok && !rsp_present && !rsp_entry_ready && !rsp_freed, "absent id reported with entry")
   `RBT_ASSERT_NOW(a_freed, rsp_valid && rsp_freed, rsp_ok && !rsp_present && (rsp_status == ST_DONE), "freed entry still present")
   `RBT_ASSERT_NOW(a_ready_present, rsp_valid && rsp_entry_ready, rsp_present, "ready flag without entry")

endmodule

bind refcounted_buffer_tracker_core rbt_checker u_rbt_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_ok           (rsp_ch.ok),
   .rsp_status       (rsp_ch.status),
   .rsp_present      (rsp_ch.present),
   .rsp_entry_ready  (rsp_ch.entry_ready),
   .rsp_freed        (rsp_ch.freed),
   .rsp_bytes_in_use (rsp_ch.bytes_in_use)
);

// ===== bench/refcounted_buffer_tracker_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// refcounted_buffer_tracker_core_test
// Self-checking bench for the buffer tracker. Request words go in over a
// valid/ready channel, in bursts. The capacity register is rewritten only
// while the block is idle. Every response word is compared field by field
// with a planned word or with a transaction-level shadow of the entry table.
// ----------------------------------------------------------------------------
module refcounted_buffer_tracker_core_test;
   import rbt_pkg::*;

   localparam int SLOTS          = TABLE_ENTRIES_DEF;
   localparam int REF_BITS       = REF_BITS_DEF;
   localparam int RESET_CYCLES   = 6;
   localparam int SETTLE_CYCLES  = 8;
   localparam int DRAIN_CYCLES   = 20;
   localparam int HOLD_AFTER     = 60;
   localparam int HOLD_CYCLES    = 150;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SHOW_LIMIT     = 10;

   // kinds the block treats as no-ops
   localparam logic [2:0] KIND_SPARE6 = 3'd6;
   localparam logic [2:0] KIND_SPARE7 = 3'd7;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] transfer_id;
      logic [31:0] request_bytes;
      logic [15:0] initial_refs;
   } tracker_req_type;

   typedef struct packed {
      logic        ok;
      status_type  status;
      logic        present;
      logic        entry_ready;
      logic        freed;
      logic [31:0] bytes_in_use;
   } tracker_rsp_type;

   typedef enum logic [1:0] {ROW_SEND, ROW_CHECK, ROW_CAPACITY} row_kind_type;

   typedef struct {
      row_kind_type    what;
      tracker_req_type word;
      tracker_rsp_type want;
      logic [31:0]     cap_value;
   } plan_row_type;

   typedef enum logic [2:0] {
      RX_ALWAYS, RX_MOSTLY, RX_HALF, RX_SPARSE, RX_ALTERNATE
   } stall_mode_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [31:0] csr_wr_data;

   rbt_req_if req_ch ();
   rbt_rsp_if rsp_ch ();

   refcounted_buffer_tracker_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // shadow of the entry table
   logic                live_slot   [SLOTS];
   logic [31:0]         slot_key    [SLOTS];
   logic [31:0]         slot_size   [SLOTS];
   logic                slot_marked [SLOTS];
   logic [REF_BITS-1:0] slot_count  [SLOTS];
   logic [31:0]         bytes_used;
   logic [31:0]         cap_limit;

   tracker_rsp_type rsp_due [$];
   plan_row_type    directed_plan [$];
   logic [31:0]     id_pool [$];

   int mismatches      = 0;
   int rsp_checked     = 0;
   int words_sent      = 0;
   int capacity_writes = 0;
   int over_cap_hits   = 0;
   int full_hits       = 0;
   int entries_freed   = 0;
   int idle_cycles     = 0;
   int burst_left      = 0;

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int find_entry(input logic [31:0] id);
      for (int s = 0; s < SLOTS; s++)
         if (live_slot[s] && slot_key[s] == id) return s;
      return -1;
   endfunction

   function automatic tracker_rsp_type predict_buffer_op(input tracker_req_type w);
      tracker_rsp_type r;
      int hit;
      int spare;
      r = '0;
      r.status = ST_DONE;
      hit = find_entry(w.transfer_id);
      case (w.kind)
         KIND_ALLOC: begin
            if (hit >= 0) begin
               r.ok = 1'b1;
               r.status = ST_PRESENT;
            end else if ({1'b0, bytes_used} + {1'b0, w.request_bytes} > {1'b0, cap_limit}) begin
               r.status = ST_OVER_CAP;
               over_cap_hits++;
            end else begin
               spare = -1;
               for (int s = SLOTS - 1; s >= 0; s--)
                  if (!live_slot[s]) spare = s;
               if (spare < 0) begin
                  r.status = ST_FULL;
                  full_hits++;
               end else begin
                  live_slot[spare]   = 1'b1;
                  slot_key[spare]    = w.transfer_id;
                  slot_size[spare]   = w.request_bytes;
                  slot_marked[spare] = 1'b0;
                  slot_count[spare]  = w.initial_refs[REF_BITS-1:0];
                  bytes_used = bytes_used + w.request_bytes;
                  r.ok = 1'b1;
               end
            end
         end
         KIND_MARK: begin
            if (hit < 0) r.status = ST_NOT_FOUND;
            else begin
               slot_marked[hit] = 1'b1;
               r.ok = 1'b1;
            end
         end
         KIND_QUERY: begin
            if (hit < 0) r.status = ST_NOT_FOUND;
            else r.ok = slot_marked[hit];
         end
         KIND_RELEASE: begin
            if (hit < 0) r.status = ST_NOT_FOUND;
            else begin
               // count floors at zero, a zero count frees on any release
               if (slot_count[hit] != 0) slot_count[hit] = slot_count[hit] - 1'b1;
               if (slot_count[hit] == 0) begin
                  bytes_used = bytes_used - slot_size[hit];
                  live_slot[hit] = 1'b0;
                  r.ok = 1'b1;
                  r.freed = 1'b1;
                  entries_freed++;
               end
            end
         end
         KIND_DEALLOC: begin
            if (hit < 0) r.status = ST_NOT_FOUND;
            else begin
               bytes_used = bytes_used - slot_size[hit];
               live_slot[hit] = 1'b0;
               r.ok = 1'b1;
               r.freed = 1'b1;
               entries_freed++;
            end
         end
         KIND_CLEAR: begin
            for (int s = 0; s < SLOTS; s++) live_slot[s] = 1'b0;
            bytes_used = '0;
            r.ok = 1'b1;
         end
         default: ;
      endcase
      hit = find_entry(w.transfer_id);
      if (hit >= 0) begin
         r.present = 1'b1;
         r.entry_ready = slot_marked[hit];
      end
      r.bytes_in_use = bytes_used;
      return r;
   endfunction

   function automatic tracker_req_type make_word(input logic [2:0] kind, input logic [31:0] id,
                                                 input logic [31:0] bytes,
                                                 input logic [15:0] refs);
      tracker_req_type w;
      w.kind = kind;
      w.transfer_id = id;
      w.request_bytes = bytes;
      w.initial_refs = refs;
      return w;
   endfunction

   function automatic void plan_send(input logic [2:0] kind, input logic [31:0] id,
                                     input logic [31:0] bytes, input logic [15:0] refs);
      plan_row_type row;
      row.what = ROW_SEND;
      row.word = make_word(kind, id, bytes, refs);
      row.want = '0;
      row.cap_value = '0;
      directed_plan.push_back(row);
   endfunction

   function automatic void plan_check(input logic [2:0] kind, input logic [31:0] id,
                                      input logic [31:0] bytes, input logic [15:0] refs,
                                      input logic ok, input status_type st, input logic pres,
                                      input logic rdy, input logic fr, input logic [31:0] biu);
      plan_row_type row;
      row.what = ROW_CHECK;
      row.word = make_word(kind, id, bytes, refs);
      row.want.ok = ok;
      row.want.status = st;
      row.want.present = pres;
      row.want.entry_ready = rdy;
      row.want.freed = fr;
      row.want.bytes_in_use = biu;
      row.cap_value = '0;
      directed_plan.push_back(row);
   endfunction

   function automatic void plan_capacity(input logic [31:0] value);
      plan_row_type row;
      row.what = ROW_CAPACITY;
      row.word = '0;
      row.want = '0;
      row.cap_value = value;
      directed_plan.push_back(row);
   endfunction

   function automatic void fresh_pool(input int n);
      id_pool.delete();
      repeat (n) id_pool.push_back($urandom);
   endfunction

   function automatic tracker_req_type random_word(input logic [31:0] bytes_hi);
      tracker_req_type w;
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 30)      w.kind = KIND_ALLOC;
      else if (roll < 45) w.kind = KIND_MARK;
      else if (roll < 60) w.kind = KIND_QUERY;
      else if (roll < 82) w.kind = KIND_RELEASE;
      else if (roll < 94) w.kind = KIND_DEALLOC;
      else if (roll < 96) w.kind = KIND_CLEAR;
      else if (roll < 98) w.kind = KIND_SPARE6;
      else                w.kind = KIND_SPARE7;
      // mostly a small pool of ids so entries live through whole lifecycles
      if (id_pool.size() != 0 && $urandom_range(0, 99) < 88)
         w.transfer_id = id_pool[$urandom_range(0, id_pool.size() - 1)];
      else
         w.transfer_id = $urandom;
      if ($urandom_range(0, 19) == 0) w.request_bytes = $urandom;
      else w.request_bytes = $urandom_range(0, bytes_hi);
      if ($urandom_range(0, 3) == 0) w.initial_refs = 16'($urandom);
      else w.initial_refs = 16'($urandom_range(0, 3));
      return w;
   endfunction

   // called at a falling edge; returns at a falling edge after the word is taken
   task automatic offer_word(input tracker_req_type w, input bit typed,
                             input tracker_rsp_type typed_rsp);
      tracker_rsp_type predicted;
      int gap;
      req_ch.valid         <= 1'b1;
      req_ch.kind          <= w.kind;
      req_ch.transfer_id   <= w.transfer_id;
      req_ch.request_bytes <= w.request_bytes;
      req_ch.initial_refs  <= w.initial_refs;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      predicted = predict_buffer_op(w);
      rsp_due.push_back(typed ? typed_rsp : predicted);
      words_sent++;
      @(negedge clock);
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   task automatic drain_then_set_capacity(input logic [31:0] value);
      req_ch.valid <= 1'b0;
      while (rsp_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      cap_limit = value;
      capacity_writes++;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // response side: stall pattern plus one long hold-off
   initial begin : rsp_stall_pattern
      stall_mode_type mode;
      int mode_left;
      bit held;
      rsp_ch.ready = 1'b0;
      mode = RX_ALWAYS;
      mode_left = 0;
      held = 1'b0;
      @(negedge clock);
      forever begin
         if (!held && rsp_checked >= HOLD_AFTER) begin
            held = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (mode_left == 0) begin
            mode = stall_mode_type'($urandom_range(0, 4));
            mode_left = $urandom_range(32, 96);
         end
         mode_left--;
         case (mode)
            RX_ALWAYS: rsp_ch.ready <= 1'b1;
            RX_MOSTLY: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
            RX_HALF:   rsp_ch.ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            default:   rsp_ch.ready <= mode_left[1];
         endcase
         @(negedge clock);
      end
   end

   always @(posedge clock) begin : rsp_check
      tracker_rsp_type want;
      if (!reset) begin
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (rsp_due.size() == 0) begin
               mismatches++;
               if (mismatches <= SHOW_LIMIT)
                  $display("response word with nothing outstanding: ok %b status %0d bytes %h",
                           rsp_ch.ok, rsp_ch.status, rsp_ch.bytes_in_use);
            end else begin
               want = rsp_due.pop_front();
               rsp_checked++;
               if (rsp_ch.ok !== want.ok || rsp_ch.status !== want.status ||
                   rsp_ch.present !== want.present ||
                   rsp_ch.entry_ready !== want.entry_ready ||
                   rsp_ch.freed !== want.freed ||
                   rsp_ch.bytes_in_use !== want.bytes_in_use) begin
                  mismatches++;
                  if (mismatches <= SHOW_LIMIT) begin
                     $display("word %0d exp/got: ok %b/%b status %0d/%0d present %b/%b",
                              rsp_checked, want.ok, rsp_ch.ok, want.status, rsp_ch.status,
                              want.present, rsp_ch.present);
                     $display("   ready %b/%b freed %b/%b bytes %h/%h",
                              want.entry_ready, rsp_ch.entry_ready, want.freed, rsp_ch.freed,
                              want.bytes_in_use, rsp_ch.bytes_in_use);
                  end
               end
            end
         end
         if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
             (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            idle_cycles = 0;
         else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
               $display("refcounted_buffer_tracker_core_test: done, errors");
               $finish;
            end
         end
      end
   end

   initial begin : stimulus
      logic [31:0] cap;
      logic [31:0] fresh_id;
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_wr_data          = '0;
      req_ch.valid         = 1'b0;
      req_ch.kind          = '0;
      req_ch.transfer_id   = '0;
      req_ch.request_bytes = '0;
      req_ch.initial_refs  = '0;
      for (int s = 0; s < SLOTS; s++) live_slot[s] = 1'b0;
      bytes_used = '0;
      cap_limit  = '0;

      // capacity is zero out of reset: only a zero-byte allocate fits
      plan_check(KIND_QUERY, 32'h0, 32'h0, 16'h0, 1'b0, ST_NOT_FOUND, 1'b0, 1'b0, 1'b0, 32'h0);
      plan_check(KIND_ALLOC, 32'hFFFF_FFFF, 32'h0, 16'h0,
                 1'b1, ST_DONE, 1'b1, 1'b0, 1'b0, 32'h0);
      plan_check(KIND_ALLOC, 32'h1, 32'h1, 16'h1, 1'b0, ST_OVER_CAP, 1'b0, 1'b0, 1'b0, 32'h0);
      plan_capacity(32'hFFFF_FFFF);
      plan_check(KIND_ALLOC, 32'h1, 32'hFFFF_FFFF, 16'hFFFF,
                 1'b1, ST_DONE, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF);
      // sum must not wrap past the capacity
      plan_check(KIND_ALLOC, 32'h2, 32'h1, 16'h1,
                 1'b0, ST_OVER_CAP, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF);
      plan_check(KIND_ALLOC, 32'h1, 32'h5, 16'h3,
                 1'b1, ST_PRESENT, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF);
      plan_send(KIND_MARK, 32'h1, 32'h0, 16'h0);
      plan_send(KIND_QUERY, 32'h1, 32'h0, 16'h0);
      plan_send(KIND_RELEASE, 32'h1, 32'h0, 16'h0);
      plan_check(KIND_DEALLOC, 32'h1, 32'h0, 16'h0, 1'b1, ST_DONE, 1'b0, 1'b0, 1'b1, 32'h0);
      plan_send(KIND_QUERY, 32'hFFFF_FFFF, 32'h0, 16'h0);
      // zero count: a single release frees it
      plan_check(KIND_RELEASE, 32'hFFFF_FFFF, 32'h0, 16'h0,
                 1'b1, ST_DONE, 1'b0, 1'b0, 1'b1, 32'h0);
      plan_check(KIND_MARK, 32'h5, 32'h0, 16'h0, 1'b0, ST_NOT_FOUND, 1'b0, 1'b0, 1'b0, 32'h0);
      plan_check(KIND_RELEASE, 32'h5, 32'h0, 16'h0, 1'b0, ST_NOT_FOUND, 1'b0, 1'b0, 1'b0, 32'h0);
      plan_check(KIND_DEALLOC, 32'h5, 32'h0, 16'h0, 1'b0, ST_NOT_FOUND, 1'b0, 1'b0, 1'b0, 32'h0);
      plan_check(KIND_SPARE6, 32'h0, 32'hFFFF_FFFF, 16'hFFFF,
                 1'b0, ST_DONE, 1'b0, 1'b0, 1'b0, 32'h0);
      plan_check(KIND_SPARE7, 32'h0, 32'hFFFF_FFFF, 16'hFFFF,
                 1'b0, ST_DONE, 1'b0, 1'b0, 1'b0, 32'h0);
      plan_send(KIND_ALLOC, 32'h0, 32'd100, 16'h2);
      plan_send(KIND_ALLOC, 32'h8000_0000, 32'd50, 16'h1);
      plan_send(KIND_MARK, 32'h8000_0000, 32'h0, 16'h0);
      plan_send(KIND_RELEASE, 32'h0, 32'h0, 16'h0);
      // capacity dropped under the bytes already held
      plan_capacity(32'd10);
      plan_send(KIND_QUERY, 32'h8000_0000, 32'h0, 16'h0);
      plan_check(KIND_ALLOC, 32'h3, 32'h0, 16'h1,
                 1'b0, ST_OVER_CAP, 1'b0, 1'b0, 1'b0, 32'd150);
      plan_check(KIND_CLEAR, 32'h0, 32'h0, 16'h0, 1'b1, ST_DONE, 1'b0, 1'b0, 1'b0, 32'h0);
      plan_check(KIND_ALLOC, 32'h3, 32'd10, 16'h1, 1'b1, ST_DONE, 1'b1, 1'b0, 1'b0, 32'd10);
      plan_send(KIND_RELEASE, 32'h3, 32'h0, 16'h0);

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_plan[r]) begin
         case (directed_plan[r].what)
            ROW_CAPACITY: drain_then_set_capacity(directed_plan[r].cap_value);
            ROW_CHECK:    offer_word(directed_plan[r].word, 1'b1, directed_plan[r].want);
            default:      offer_word(directed_plan[r].word, 1'b0, '0);
         endcase
      end

      // mid capacity, lifecycles over a small id pool
      drain_then_set_capacity(32'd1000);
      fresh_pool(16);
      repeat (150) offer_word(random_word(32'd120), 1'b0, '0);

      // unlimited capacity: fill every slot, then push past it
      drain_then_set_capacity(32'hFFFF_FFFF);
      offer_word(make_word(KIND_CLEAR, 32'h0, 32'h0, 16'h0), 1'b0, '0);
      id_pool.delete();
      repeat (SLOTS + 6) begin
         fresh_id = $urandom;
         id_pool.push_back(fresh_id);
         offer_word(make_word(KIND_ALLOC, fresh_id, $urandom_range(0, 4096),
                              16'($urandom_range(1, 3))), 1'b0, '0);
      end
      repeat (30) offer_word(random_word(32'd4096), 1'b0, '0);

      cap = $urandom_range(0, 400);
      drain_then_set_capacity(cap);
      fresh_pool(12);
      repeat (100) offer_word(random_word(32'd60), 1'b0, '0);

      drain_then_set_capacity(32'h0);
      repeat (30) offer_word(random_word(32'd8), 1'b0, '0);

      cap = $urandom;
      drain_then_set_capacity(cap);
      fresh_pool(16);
      repeat (70) offer_word(random_word(cap >> 3), 1'b0, '0);

      req_ch.valid <= 1'b0;
      while (rsp_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (rsp_due.size() != 0) mismatches += rsp_due.size();

      $display("%0d request words, %0d responses checked, %0d capacity writes",
               words_sent, rsp_checked, capacity_writes);
      $display("refusals: %0d over capacity, %0d table full; %0d entries freed",
               over_cap_hits, full_hits, entries_freed);
      if (mismatches == 0)
         $display("refcounted_buffer_tracker_core_test: done, clean");
      else
         $display("refcounted_buffer_tracker_core_test: done, errors");
      $finish;
   end

endmodule

// ===== refcounted_buffer_tracker_core.f =====
+incdir+hdl
hdl/rbt_pkg.sv
hdl/rbt_ifs.sv
hdl/rbt_ram.sv
hdl/rbt_front.sv
hdl/rbt_back.sv
hdl/refcounted_buffer_tracker_core.sv
hdl/rbt_checker.sv
bench/refcounted_buffer_tracker_core_test.sv
